@@ design/dcl_pkg.sv @@
package dcl_pkg;

    localparam int VALUE_BITS  = 30;
    localparam int PRIME_LIMIT = 32768;
    localparam int PRIME_COUNT = 3512;
    localparam int LEN_BITS    = 5;

    localparam int PRIME_BITS = $clog2(PRIME_LIMIT);
    localparam int CAND_BITS  = PRIME_BITS + 1;
    localparam int ADDR_BITS  = $clog2(PRIME_COUNT);
    localparam int CNT_BITS   = $clog2(PRIME_COUNT + 1);
    localparam int STEP_BITS  = $clog2(VALUE_BITS);

    localparam logic [LEN_BITS-1:0]  LEN_MAX       = '1;
    localparam logic [CNT_BITS-1:0]  PRIME_COUNT_C = CNT_BITS'(PRIME_COUNT);
    localparam logic [CAND_BITS-1:0] CAND_LIMIT    = CAND_BITS'(PRIME_LIMIT);
    localparam logic [STEP_BITS-1:0] STEP_LAST     = STEP_BITS'(VALUE_BITS - 1);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DIV       = 9'b000000010,
        ST_EVAL      = 9'b000000100,
        ST_CHECK     = 9'b000001000,
        ST_READ      = 9'b000010000,
        ST_LOAD      = 9'b000100000,
        ST_DONE      = 9'b001000000,
        ST_FILL_NEXT = 9'b010000000,
        ST_FILL_WR   = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        MODE_SDIV = 2'd0,
        MODE_FACT = 2'd1,
        MODE_FILL = 2'd2
    } mode_t;

endpackage

@@ design/dcl_ram.sv @@
module dcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/divisor_chain_length_top.sv @@
// Channel   Direction  Handshake            Payload
// request   in         start, busy          start_value, target_value
// result    out        done (one cycle)     chain_length
//
// After reset the prime table RAM is filled by trial division of each odd
// candidate below the prime limit, reusing the divider, and busy stays high
// throughout. A transaction runs one restoring division (one bit per cycle)
// for target/start and one per trial prime or found factor.
// The result strobe lasts one cycle and the receiver cannot stall it.
module divisor_chain_length_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dcl_pkg::VALUE_BITS-1:0]  start_value,
    input  logic [dcl_pkg::VALUE_BITS-1:0]  target_value,
    output logic                            done,
    output logic [dcl_pkg::LEN_BITS-1:0]    chain_length
);

    import dcl_pkg::*;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [VALUE_BITS-1:0]  rem_reg, rem_next;
    logic [VALUE_BITS-1:0]  quo_reg, quo_next;
    logic [VALUE_BITS-1:0]  dsr_reg, dsr_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    logic [VALUE_BITS-1:0]  q_reg, q_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [CNT_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [CAND_BITS-1:0]   cand_reg, cand_next;

    logic [VALUE_BITS:0]    trial;
    logic [VALUE_BITS+1:0]  diff;
    logic                   fits;
    logic [LEN_BITS-1:0]    len_inc;
    logic [CAND_BITS-1:0]   cand_adv;
    logic                   ram_we;
    logic [PRIME_BITS-1:0]  ram_rdata;

    // One restoring division step: shift in the next dividend bit and subtract.
    assign trial    = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff     = {1'b0, trial} - {2'b00, dsr_reg};
    assign fits     = !diff[VALUE_BITS+1];
    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + LEN_BITS'(1);
    // Candidates run 2, 3, 5, 7, ... so only odd values are tested after 2.
    assign cand_adv = cand_reg + (cand_reg[0] ? CAND_BITS'(2) : CAND_BITS'(1));
    assign ram_we   = (state_reg == ST_FILL_WR);

    dcl_ram #(
        .WIDTH (PRIME_BITS),
        .DEPTH (PRIME_COUNT)
    ) u_prime_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_BITS-1:0]),
        .wdata (cand_reg[PRIME_BITS-1:0]),
        .raddr (idx_reg[ADDR_BITS-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        step_next  = step_reg;
        q_next     = q_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        cand_next  = cand_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (start_value == '0 || target_value == '0)
                    begin
                        len_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mode_next  = MODE_SDIV;
                        quo_next   = target_value;
                        rem_next   = '0;
                        dsr_next   = start_value;
                        step_next  = STEP_LAST;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                rem_next = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    step_next = step_reg - STEP_BITS'(1);
                end
            end

            ST_EVAL:
            begin
                // A quotient below the divisor means divisor squared exceeds
                // the dividend, so no smaller factor is left to find.
                case (mode_reg)
                    MODE_SDIV:
                    begin
                        if (rem_reg != '0)
                        begin
                            len_next   = '0;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            mode_next  = MODE_FACT;
                            q_next     = quo_reg;
                            len_next   = LEN_BITS'(1);
                            idx_next   = '0;
                            state_next = ST_CHECK;
                        end
                    end
                    MODE_FACT:
                    begin
                        if (rem_reg == '0)
                        begin
                            q_next     = quo_reg;
                            len_next   = len_inc;
                            state_next = ST_CHECK;
                        end
                        else if (quo_reg < dsr_reg)
                        begin
                            len_next   = len_inc;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CNT_BITS'(1);
                            state_next = ST_CHECK;
                        end
                    end
                    MODE_FILL:
                    begin
                        if (rem_reg == '0)
                        begin
                            cand_next  = cand_adv;
                            state_next = ST_FILL_NEXT;
                        end
                        else if (quo_reg < dsr_reg)
                        begin
                            state_next = ST_FILL_WR;
                        end
                        else
                        begin
                            idx_next   = idx_reg + CNT_BITS'(1);
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_CHECK:
            begin
                if (q_reg <= VALUE_BITS'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                // Running out of known primes means the value left is prime.
                if (idx_reg == count_reg)
                begin
                    if (mode_reg == MODE_FILL)
                    begin
                        state_next = ST_FILL_WR;
                    end
                    else
                    begin
                        len_next   = len_inc;
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                quo_next   = (mode_reg == MODE_FILL)
                           ? {{(VALUE_BITS-CAND_BITS){1'b0}}, cand_reg} : q_reg;
                rem_next   = '0;
                dsr_next   = {{(VALUE_BITS-PRIME_BITS){1'b0}}, ram_rdata};
                step_next  = STEP_LAST;
                state_next = ST_DIV;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            ST_FILL_NEXT:
            begin
                if (cand_reg >= CAND_LIMIT || count_reg == PRIME_COUNT_C)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mode_next  = MODE_FILL;
                    idx_next   = CNT_BITS'(1);
                    state_next = ST_READ;
                end
            end

            ST_FILL_WR:
            begin
                count_next = count_reg + CNT_BITS'(1);
                cand_next  = cand_adv;
                state_next = ST_FILL_NEXT;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL_WR;
            mode_reg  <= MODE_FILL;
            len_reg   <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
            cand_reg  <= CAND_BITS'(2);
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        step_reg <= step_next;
        q_reg    <= q_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign chain_length = len_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_reg < PRIME_COUNT_C && !done))
        else $error("prime table write beyond its depth");

    a_read_known: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (idx_reg < count_reg))
        else $error("prime table read of an entry not yet filled");

endmodule

@@ tb/tb_divisor_chain_length_top.sv @@
module tb_divisor_chain_length_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VB = dcl_pkg::VALUE_BITS;
    localparam int LB = dcl_pkg::LEN_BITS;
    localparam longint unsigned VALUE_MAX = (longint'(1) << VB) - 1;
    localparam int unsigned LEN_SAT = (1 << LB) - 1;
    // Nothing is accepted while the table fill after reset runs.
    localparam int unsigned WATCHDOG_LIMIT = 20_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_ITEMS = 100;
    localparam int unsigned SMALL_PRIMES [16] =
        '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};

    typedef struct {
        logic [VB-1:0] s;
        logic [VB-1:0] t;
        bit            wait_idle;
    } chain_req_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic [VB-1:0] start_value = '0;
    logic [VB-1:0] target_value = '0;
    logic          busy;
    logic          done;
    logic [LB-1:0] chain_length;

    chain_req_t    pending_pairs_q[$];
    logic [LB-1:0] expected_len_q[$];
    chain_req_t    next_req;

    int unsigned n_issued = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_zero_len = 0;
    int unsigned longest_len = 0;
    int unsigned n_errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    divisor_chain_length_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .start_value  (start_value),
        .target_value (target_value),
        .done         (done),
        .chain_length (chain_length)
    );

    always #10 clk = ~clk;

    // Trial division by every integer is equivalent to trial division by primes,
    // since a composite divisor never divides once its prime factors are gone.
    function automatic logic [LB-1:0] chain_len_predict(logic [VB-1:0] s, logic [VB-1:0] t);
        longint unsigned q;
        longint unsigned d;
        int unsigned n;
        if (s == 0 || t == 0 || (t % s) != 0)
            return '0;
        q = t / s;
        n = 1;
        d = 2;
        while (q > 1 && d * d <= q)
        begin
            while (q % d == 0)
            begin
                q = q / d;
                n++;
            end
            d++;
        end
        if (q > 1)
            n++;
        if (n > LEN_SAT)
            n = LEN_SAT;
        return n[LB-1:0];
    endfunction

    function automatic void queue_pair(longint unsigned s, longint unsigned t, bit wait_idle);
        chain_req_t r;
        r.s = s[VB-1:0];
        r.t = t[VB-1:0];
        r.wait_idle = wait_idle;
        pending_pairs_q = {pending_pairs_q, r};
    endfunction

    // A start value times a quotient made of small primes and one bounded cofactor,
    // so the trial division stays short.
    function automatic void queue_divisible(int unsigned cof_max, bit wait_idle);
        longint unsigned s;
        longint unsigned q;
        longint unsigned lim;
        longint unsigned f;
        int unsigned w;
        int unsigned nf;
        w = $urandom_range(29, 1);
        s = $urandom_range((32'd1 << w) - 1, 1);
        lim = VALUE_MAX / s;
        q = 1;
        nf = $urandom_range(29, 0);
        for (int k = 0; k < nf; k++)
        begin
            if ($urandom_range(2, 0) == 0)
                f = 2;
            else
                f = SMALL_PRIMES[$urandom_range(15, 0)];
            if (q * f <= lim)
                q = q * f;
        end
        if (cof_max > 1)
        begin
            f = $urandom_range(cof_max, 1);
            if (q * f <= lim)
                q = q * f;
        end
        queue_pair(s, s * q, wait_idle);
    endfunction

    // Driver: a new transaction is offered only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || n_accepted == n_issued)
        begin
            if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (pending_pairs_q.size() == 0)
                start <= 1'b0;
            else if (pending_pairs_q[0].wait_idle && expected_len_q.size() != 0)
                start <= 1'b0;
            else
            begin
                next_req = pending_pairs_q.pop_front();
                start_value <= next_req.s;
                target_value <= next_req.t;
                start <= 1'b1;
                n_issued++;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(8, 1);
                    if ($urandom_range(3, 0) == 0)
                        gap_left = $urandom_range(60, 5);
                    else
                        gap_left = $urandom_range(4, 0);
                end
                else
                    burst_left--;
            end
        end
    end

    // Monitor: results are checked before the transaction accepted at the same edge
    // is queued, since that result cannot come out yet.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                n_results++;
                if (chain_length == 0)
                    n_zero_len++;
                if (chain_length > longest_len)
                    longest_len = chain_length;
                if (expected_len_q.size() == 0)
                begin
                    $error("chain_length: result with no transaction pending, actual %0d",
                           chain_length);
                    n_errors++;
                end
                else
                begin
                    if (chain_length !== expected_len_q[0])
                    begin
                        $error("chain_length mismatch: expected %0d, actual %0d",
                               expected_len_q[0], chain_length);
                        n_errors++;
                    end
                    void'(expected_len_q.pop_front());
                end
            end
            if (start && !busy)
            begin
                expected_len_q = {expected_len_q,
                                  chain_len_predict(start_value, target_value)};
                n_accepted++;
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned pick;
        longint unsigned s;
        longint unsigned t;

        // Directed pairs: edges of both fields, zero operands, deepest factoring.
        queue_pair(1, 1, 0);
        queue_pair(1, 2, 0);
        queue_pair(2, 2, 0);
        queue_pair(1, 4, 0);
        queue_pair(0, 12, 0);
        queue_pair(5, 0, 0);
        queue_pair(0, 0, 0);
        queue_pair(2, 3, 0);
        queue_pair(6, 3, 0);
        queue_pair(1024, 1023, 0);
        queue_pair(VALUE_MAX, VALUE_MAX, 1);
        queue_pair(1, VALUE_MAX, 0);
        queue_pair(VALUE_MAX, 1, 0);
        queue_pair(30'h1555_5555, 30'h2AAA_AAAA, 0);
        queue_pair(30'h2AAA_AAAA, 30'h1555_5555, 0);
        queue_pair(1, 536870912, 0);
        queue_pair(1, 387420489, 0);
        queue_pair(1, 223092870, 0);
        queue_pair(12345, 12345 * 64, 0);
        queue_pair(1, 65498, 0);
        // Largest prime below the value range, and the square of the largest table prime.
        queue_pair(1, 1073741789, 0);
        queue_pair(1, 1072497001, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 55)
                queue_divisible(65535, (i % 50) == 0);
            else if (pick < 65)
                queue_divisible(1 << 24, (i % 50) == 0);
            else if (pick < 72)
            begin
                // Nearly divisible: one off a multiple.
                s = $urandom_range(32'h3FFF_FFFF, 2);
                t = s * $urandom_range(32'h3FFF_FFFF / s, 1);
                if (t < VALUE_MAX && $urandom_range(1, 0) == 1)
                    t = t + 1;
                else
                    t = t - 1;
                queue_pair(s, t, (i % 50) == 0);
            end
            else if (pick < 95)
            begin
                s = $urandom_range(32'h3FFF_FFFF, 32'd1 << 20);
                t = $urandom & VALUE_MAX;
                queue_pair(s, t, (i % 50) == 0);
            end
            else
            begin
                s = ($urandom_range(1, 0) == 0) ? 0 : ($urandom & VALUE_MAX);
                t = (s != 0) ? 0 : ($urandom & VALUE_MAX);
                queue_pair(s, t, (i % 50) == 0);
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_pairs_q.size() != 0 || n_accepted != n_issued)
            @(posedge clk);
        while (expected_len_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions and %0d results: %0d non-divisible or zero,",
                 n_accepted, n_results, n_zero_len);
        $display("%0d divisible with chain lengths up to %0d.",
                 n_results - n_zero_len, longest_len);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
design/dcl_pkg.sv
design/dcl_ram.sv
design/divisor_chain_length_top.sv
tb/tb_divisor_chain_length_top.sv
